/* src/archive_block_descrambler_defines.svh */
// Assertion macros used by the descrambler RTL.
`ifndef ARCHIVE_BLOCK_DESCRAMBLER_DEFINES_SVH
`define ARCHIVE_BLOCK_DESCRAMBLER_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define ABD_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A condition that must be followed by a consequence at the next clock edge.
`define ABD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/abd_pkg.sv */
// Constants, tables and block transforms of the archive block descrambler.
package abd_pkg;

  localparam int DATA_W = 64;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [4:0] HEADER_BLOCKS = 5'd20;

  // Register indexes of the configuration port.
  localparam logic REG_MODE  = 1'b0;
  localparam logic REG_DIGIT = 1'b1;

  // Operating modes.
  localparam logic [1:0] MODE_HEADER = 2'd0;
  localparam logic [1:0] MODE_MIXED  = 2'd1;
  localparam logic [1:0] MODE_NAME   = 2'd2;

  localparam logic [1:0] MODE_RESET  = MODE_HEADER;
  localparam logic [3:0] DIGIT_RESET = 4'd1;

  // Standard initial permutation, 1-based, bit 1 is the top bit.
  localparam logic [6:0] PERM_IN [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  // Standard final permutation, 1-based.
  localparam logic [6:0] PERM_OUT [64] = '{
    7'd40, 7'd8,  7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7,  7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6,  7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5,  7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4,  7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3,  7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2,  7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1,  7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  // Permutation applied to the 32-bit substitution result, 1-based.
  localparam logic [5:0] PERM_ROUND [32] = '{
    6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
    6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
    6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
    6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
  };

  // Paired-nibble substitution tables: high nibble from the even group,
  // low nibble from the odd group.
  localparam logic [7:0] SUB_TAB [4][64] = '{
    '{
      8'hef, 8'h03, 8'h41, 8'hfd, 8'hd8, 8'h74, 8'h1e, 8'h47,
      8'h26, 8'hef, 8'hfb, 8'h22, 8'hb3, 8'hd8, 8'h84, 8'h1e,
      8'h39, 8'hac, 8'ha7, 8'h60, 8'h62, 8'hc1, 8'hcd, 8'hba,
      8'h5c, 8'h96, 8'h90, 8'h59, 8'h05, 8'h3b, 8'h7a, 8'h85,
      8'h40, 8'hfd, 8'h1e, 8'hc8, 8'he7, 8'h8a, 8'h8b, 8'h21,
      8'hda, 8'h43, 8'h64, 8'h9f, 8'h2d, 8'h14, 8'hb1, 8'h72,
      8'hf5, 8'h5b, 8'hc8, 8'hb6, 8'h9c, 8'h37, 8'h76, 8'hec,
      8'h39, 8'ha0, 8'ha3, 8'h05, 8'h52, 8'h6e, 8'h0f, 8'hd9
    },
    '{
      8'ha7, 8'hdd, 8'h0d, 8'h78, 8'h9e, 8'h0b, 8'he3, 8'h95,
      8'h60, 8'h36, 8'h36, 8'h4f, 8'hf9, 8'h60, 8'h5a, 8'ha3,
      8'h11, 8'h24, 8'hd2, 8'h87, 8'hc8, 8'h52, 8'h75, 8'hec,
      8'hbb, 8'hc1, 8'h4c, 8'hba, 8'h24, 8'hfe, 8'h8f, 8'h19,
      8'hda, 8'h13, 8'h66, 8'haf, 8'h49, 8'hd0, 8'h90, 8'h06,
      8'h8c, 8'h6a, 8'hfb, 8'h91, 8'h37, 8'h8d, 8'h0d, 8'h78,
      8'hbf, 8'h49, 8'h11, 8'hf4, 8'h23, 8'he5, 8'hce, 8'h3b,
      8'h55, 8'hbc, 8'ha2, 8'h57, 8'he8, 8'h22, 8'h74, 8'hce
    },
    '{
      8'h2c, 8'hea, 8'hc1, 8'hbf, 8'h4a, 8'h24, 8'h1f, 8'hc2,
      8'h79, 8'h47, 8'ha2, 8'h7c, 8'hb6, 8'hd9, 8'h68, 8'h15,
      8'h80, 8'h56, 8'h5d, 8'h01, 8'h33, 8'hfd, 8'hf4, 8'hae,
      8'hde, 8'h30, 8'h07, 8'h9b, 8'he5, 8'h83, 8'h9b, 8'h68,
      8'h49, 8'hb4, 8'h2e, 8'h83, 8'h1f, 8'hc2, 8'hb5, 8'h7c,
      8'ha2, 8'h19, 8'hd8, 8'he5, 8'h7c, 8'h2f, 8'h83, 8'hda,
      8'hf7, 8'h6b, 8'h90, 8'hfe, 8'hc4, 8'h01, 8'h5a, 8'h97,
      8'h61, 8'ha6, 8'h3d, 8'h40, 8'h0b, 8'h58, 8'he6, 8'h3d
    },
    '{
      8'h4d, 8'hd1, 8'hb2, 8'h0f, 8'h28, 8'hbd, 8'he4, 8'h78,
      8'hf6, 8'h4a, 8'h0f, 8'h93, 8'h8b, 8'h17, 8'hd1, 8'ha4,
      8'h3a, 8'hec, 8'hc9, 8'h35, 8'h93, 8'h56, 8'h7e, 8'hcb,
      8'h55, 8'h20, 8'ha0, 8'hfe, 8'h6c, 8'h89, 8'h17, 8'h62,
      8'h17, 8'h62, 8'h4b, 8'hb1, 8'hb4, 8'hde, 8'hd1, 8'h87,
      8'hc9, 8'h14, 8'h3c, 8'h4a, 8'h7e, 8'ha8, 8'he2, 8'h7d,
      8'ha0, 8'h9f, 8'hf6, 8'h5c, 8'h6a, 8'h09, 8'h8d, 8'hf0,
      8'h0f, 8'he3, 8'h53, 8'h25, 8'h95, 8'h36, 8'h28, 8'hcb
    }
  };

  // Initial permutation: result bit i from the top is source bit PERM_IN[i].
  function automatic logic [63:0] perm_in64(input logic [63:0] x);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      r[63 - i] = x[6'(64 - int'(PERM_IN[i]))];
    end
    return r;
  endfunction

  // Final permutation.
  function automatic logic [63:0] perm_out64(input logic [63:0] x);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      r[63 - i] = x[6'(64 - int'(PERM_OUT[i]))];
    end
    return r;
  endfunction

  // One unkeyed round: expand the right half, substitute, permute, and
  // fold into the left half. The halves are not swapped.
  function automatic logic [63:0] one_round(input logic [63:0] x);
    logic [7:0]  b4, b5, b6, b7;
    logic [5:0]  e [8];
    logic [7:0]  hi, lo;
    logic [31:0] sv, pv;
    b4 = x[31:24];
    b5 = x[23:16];
    b6 = x[15:8];
    b7 = x[7:0];
    e[0] = {b7[0], b4[7:3]};
    e[1] = {b4[4:0], b5[7]};
    e[2] = {b4[0], b5[7:3]};
    e[3] = {b5[4:0], b6[7]};
    e[4] = {b5[0], b6[7:3]};
    e[5] = {b6[4:0], b7[7]};
    e[6] = {b6[0], b7[7:3]};
    e[7] = {b7[4:0], b4[7]};
    sv = '0;
    for (int k = 0; k < 4; k++) begin
      hi = SUB_TAB[k][e[2 * k]];
      lo = SUB_TAB[k][e[2 * k + 1]];
      sv[31 - 8 * k -: 8] = {hi[7:4], lo[3:0]};
    end
    pv = '0;
    for (int k = 0; k < 32; k++) begin
      pv[31 - k] = sv[5'(32 - int'(PERM_ROUND[k]))];
    end
    return x ^ {pv, 32'd0};
  endfunction

  function automatic logic [63:0] decode_block(input logic [63:0] x);
    return perm_out64(one_round(perm_in64(x)));
  endfunction

  // Swap the two nibbles of every byte.
  function automatic logic [63:0] nibble_swap(input logic [63:0] x);
    return ((x >> 4) & 64'h0f0f0f0f0f0f0f0f) | ((x << 4) & 64'hf0f0f0f0f0f0f0f0);
  endfunction

  // Paired swaps applied to the last byte of a shuffled block.
  function automatic logic [7:0] map_last(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00:   r = 8'h2b;
      8'h2b:   r = 8'h00;
      8'h01:   r = 8'h68;
      8'h68:   r = 8'h01;
      8'h48:   r = 8'h77;
      8'h77:   r = 8'h48;
      8'h60:   r = 8'hff;
      8'hff:   r = 8'h60;
      8'h6c:   r = 8'h80;
      8'h80:   r = 8'h6c;
      8'hb9:   r = 8'hc0;
      8'hc0:   r = 8'hb9;
      8'heb:   r = 8'hfe;
      8'hfe:   r = 8'heb;
      default: r = a;
    endcase
    return r;
  endfunction

  // Byte shuffle: bytes (0 on top) reordered to 3,4,6,0,1,2,5, last mapped.
  function automatic logic [63:0] shuffle_block(input logic [63:0] x);
    return {x[39:32], x[31:24], x[15:8], x[63:56], x[55:48], x[47:40],
            x[23:16], map_last(x[7:0])};
  endfunction

  // Decode cycle of mixed mode from the digit count.
  function automatic logic [4:0] cycle_of(input logic [3:0] d);
    logic [4:0] c;
    if (d < 4'd3) begin
      c = 5'd3;
    end else if (d < 4'd5) begin
      c = {1'b0, d} + 5'd1;
    end else if (d < 4'd7) begin
      c = {1'b0, d} + 5'd9;
    end else begin
      c = {1'b0, d} + 5'd15;
    end
    return c;
  endfunction

endpackage

/* src/archive_block_descrambler.sv */
// Top level of the archive block descrambler: counters, decode pipeline, registers.
//
// Decodes a stream of 8-byte archive blocks. Each beat on the in_ channel
// carries one encoded block in in_tdata (first byte in bits 63:56) and a
// first-of-file flag in in_tuser that restarts the block counters. Each input
// beat yields exactly one output beat on the out_ channel, in order.
// Depending on the mode register a block is decoded (permutation, one fixed
// round, final permutation), nibble-swapped and decoded, byte-shuffled, or
// passed unchanged. The decision is made from the counters when the beat is
// taken; the transform runs between the input stage and the output register.
// A block goes from the input stage to the output register, which drives out_tvalid.
// Throughput is one block per cycle while the receiver holds out_tready high.
// If the receiver stalls, the output register holds its beat and the input
// stage takes one more beat before in_tready drops.
// Reset (synchronous, rst_n low) empties both stages, clears the counters, sets mode
// to header-only and the digit count to one. The user must write the registers over
// the APB-style cfg_ port only while no block is in flight; no logic enforces it.
module archive_block_descrambler (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input channel
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [abd_pkg::DATA_W-1:0]   in_tdata,   // [63:0] data_block
  input  logic                         in_tuser,   // [0] first_block
  // Output channel
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [abd_pkg::DATA_W-1:0]   out_tdata,  // [63:0] plain_block
  // Configuration port
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [abd_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [abd_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [abd_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);

  import abd_pkg::*;

  `include "archive_block_descrambler_defines.svh"

  typedef enum logic [1:0] {
    OP_PASS,
    OP_DECODE,
    OP_NAME_DECODE,
    OP_SHUFFLE
  } op_t;

  logic [1:0]        mode_r;
  logic [3:0]        digit_count_r;
  logic [4:0]        block_index_r, block_index_nxt;
  logic [4:0]        cycle_residue_r, cycle_residue_nxt;
  logic [2:0]        shuffle_count_r, shuffle_count_nxt;

  logic              s1_valid_r;
  logic [DATA_W-1:0] s1_data_r;
  op_t               s1_op_r, op_nxt;

  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r, out_data_nxt;

  logic              cfg_write;
  logic              in_fire;
  logic              out_load;
  logic [4:0]        bi, cr;
  logic [2:0]        sc;
  logic [4:0]        cyc;
  logic [5:0]        cr_inc;
  logic [DATA_W-1:0] dec_src;

  // Configuration registers.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_RESET;
      digit_count_r <= DIGIT_RESET;
    end else if (cfg_write) begin
      case (cfg_paddr[2])
        REG_MODE:  mode_r        <= cfg_pwdata[1:0];
        REG_DIGIT: digit_count_r <= cfg_pwdata[3:0];
        default:   mode_r        <= mode_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_MODE:  cfg_prdata = {{(CFG_DW-2){1'b0}}, mode_r};
      REG_DIGIT: cfg_prdata = {{(CFG_DW-4){1'b0}}, digit_count_r};
      default:   cfg_prdata = '0;
    endcase
  end

  // Pipeline flow control: the output register loads when empty or drained.
  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  // Counter update and per-block decision for the accepted beat.
  always_comb begin
    bi     = in_tuser ? 5'd0 : block_index_r;
    cr     = in_tuser ? 5'd0 : cycle_residue_r;
    sc     = in_tuser ? 3'd0 : shuffle_count_r;
    cyc    = cycle_of(digit_count_r);
    cr_inc = {1'b0, cr} + 6'd1;

    shuffle_count_nxt = sc;
    if (mode_r == MODE_NAME) begin
      op_nxt = OP_NAME_DECODE;
    end else if (bi < HEADER_BLOCKS || (mode_r == MODE_MIXED && cr == 5'd0)) begin
      op_nxt = OP_DECODE;
    end else if (mode_r == MODE_MIXED && sc == 3'd7) begin
      op_nxt            = OP_SHUFFLE;
      shuffle_count_nxt = 3'd1;
    end else begin
      op_nxt            = OP_PASS;
      shuffle_count_nxt = sc + 3'd1;
    end

    block_index_nxt   = (bi < HEADER_BLOCKS) ? bi + 5'd1 : bi;
    cycle_residue_nxt = (cr_inc >= {1'b0, cyc}) ? 5'd0 : cr_inc[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_index_r   <= '0;
      cycle_residue_r <= '0;
      shuffle_count_r <= '0;
    end else if (in_fire) begin
      block_index_r   <= block_index_nxt;
      cycle_residue_r <= cycle_residue_nxt;
      shuffle_count_r <= shuffle_count_nxt;
    end
  end

  // Input stage: encoded block and its operation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_tdata;
      s1_op_r   <= op_nxt;
    end
  end

  // Block transform between the input stage and the output register.
  always_comb begin
    dec_src = (s1_op_r == OP_NAME_DECODE) ? nibble_swap(s1_data_r) : s1_data_r;
    case (s1_op_r)
      OP_DECODE,
      OP_NAME_DECODE: out_data_nxt = decode_block(dec_src);
      OP_SHUFFLE:     out_data_nxt = shuffle_block(s1_data_r);
      default:        out_data_nxt = s1_data_r;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks on counters and pipeline hold behavior.
  `ABD_ASSERT_ALWAYS(a_index_sat, block_index_r <= HEADER_BLOCKS, "block index above header count")
  `ABD_ASSERT_ALWAYS(a_residue_rng, cycle_residue_r <= 5'd29, "cycle residue out of range")
  `ABD_ASSERT_NEXT(a_first_restart, in_fire && in_tuser, block_index_r == 5'd1 && cycle_residue_r == 5'd1, "first block did not restart counters")
  `ABD_ASSERT_NEXT(a_s1_hold, s1_valid_r && !out_load, s1_valid_r && $stable(s1_data_r), "input stage lost a waiting block")

endmodule
